/* sv/circular_queue_engine_defines.svh */
// Assertion macros shared by the circular queue engine RTL.
// No dependencies; the files that check their own logic include this header.
`ifndef CIRCULAR_QUEUE_ENGINE_DEFINES_SVH
`define CIRCULAR_QUEUE_ENGINE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// A condition that must hold at every clock edge outside reset.
`define CQE_ASSERT(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("circular queue engine check failed");

// A condition that must hold whenever a trigger holds in the same cycle.
`define CQE_ASSERT_IMPLIES(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("circular queue engine check failed");

`else

`define CQE_ASSERT(label, cond)
`define CQE_ASSERT_IMPLIES(label, trig, cond)

`endif

`endif

/* sv/cqe_pkg.sv */
// Types and constants of the circular queue engine.
// No dependencies; the interfaces, datapath, controller and top module refer to it by scoped names.
package cqe_pkg;

    localparam int DATA_W = 32;

    // Command codes of a request.
    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_ENQ   = 2'd1,
        CMD_DEQ   = 2'd2,
        CMD_TRAV  = 2'd3
    } cmd_t;

    // Status codes of a result.
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_OVERFLOW  = 3'd1,
        ST_UNDERFLOW = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_DRAINED   = 3'd4
    } status_t;

    // Controller states.
    typedef enum logic {
        S_IDLE = 1'b0,
        S_EMIT = 1'b1
    } fsm_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // a request is taken this cycle
        logic step;   // a traversal result is taken and more follow
    } ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last;   // the result on show is the final one of its request
    } dp_stat_t;

endpackage

/* sv/cqe_if.sv */
// Valid/ready channel interfaces for requests and results.
// Depends on cqe_pkg for the command and status types.
interface cqe_cmd_if;
    logic                              valid;
    logic                              ready;
    cqe_pkg::cmd_t                     command;
    logic signed [cqe_pkg::DATA_W-1:0] data_in;

    modport source (output valid, output command, output data_in, input ready);
    modport sink   (input valid, input command, input data_in, output ready);
endinterface

interface cqe_res_if;
    logic                              valid;
    logic                              ready;
    cqe_pkg::status_t                  status;
    logic signed [cqe_pkg::DATA_W-1:0] data_out;
    logic                              last;

    modport source (output valid, output status, output data_out, output last, input ready);
    modport sink   (input valid, input status, input data_out, input last, output ready);
endinterface

/* sv/cqe_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module cqe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/cqe_datapath.sv */
// Datapath of the circular queue engine: indices, occupancy, storage and result.
// Depends on cqe_pkg, cqe_ram and the assertion macros header.
`include "circular_queue_engine_defines.svh"

module cqe_datapath #(
    parameter int DEPTH = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  cqe_pkg::ctl_t                     ctl,
    input  cqe_pkg::cmd_t                     command,
    input  logic signed [cqe_pkg::DATA_W-1:0] data_in,
    output cqe_pkg::dp_stat_t                 stat,
    output cqe_pkg::status_t                  status,
    output logic signed [cqe_pkg::DATA_W-1:0] data_out,
    output logic                              last
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [IDX_W-1:0]          head_reg, head_next;
    logic [IDX_W-1:0]          tail_reg, tail_next;
    logic [CNT_W-1:0]          occ_reg, occ_next;
    logic [IDX_W-1:0]          trav_reg, trav_next;
    logic [CNT_W-1:0]          left_reg, left_next;
    cqe_pkg::status_t          status_reg, status_next;
    logic                      sel_ram_reg, sel_ram_next;

    logic                      wr_en;
    logic                      rd_en;
    logic [IDX_W-1:0]          rd_addr;
    logic [cqe_pkg::DATA_W-1:0] rd_data;
    logic                      full;
    logic                      empty;

    // Index that follows idx around the ring.
    function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] res;
        if (idx == IDX_W'(DEPTH - 1))
        begin
            res = '0;
        end
        else
        begin
            res = idx + 1'b1;
        end
        return res;
    endfunction

    assign full  = (occ_reg == CNT_W'(DEPTH));
    assign empty = (occ_reg == '0);

    // Request decode and traversal stepping.
    always_comb
    begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        occ_next     = occ_reg;
        trav_next    = trav_reg;
        left_next    = left_reg;
        status_next  = status_reg;
        sel_ram_next = sel_ram_reg;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = head_reg;

        if (ctl.load)
        begin
            left_next    = '0;
            sel_ram_next = 1'b0;
            case (command)
                cqe_pkg::CMD_CLEAR:
                begin
                    head_next   = '0;
                    tail_next   = '0;
                    occ_next    = '0;
                    status_next = cqe_pkg::ST_EMPTY;
                end
                cqe_pkg::CMD_ENQ:
                begin
                    if (full)
                    begin
                        status_next = cqe_pkg::ST_OVERFLOW;
                    end
                    else
                    begin
                        wr_en       = 1'b1;
                        tail_next   = wrap_next(tail_reg);
                        occ_next    = occ_reg + 1'b1;
                        status_next = cqe_pkg::ST_OK;
                    end
                end
                cqe_pkg::CMD_DEQ:
                begin
                    if (empty)
                    begin
                        status_next = cqe_pkg::ST_UNDERFLOW;
                    end
                    else
                    begin
                        rd_en        = 1'b1;
                        sel_ram_next = 1'b1;
                        occ_next     = occ_reg - 1'b1;
                        if (occ_reg == CNT_W'(1))
                        begin
                            head_next   = '0;
                            tail_next   = '0;
                            status_next = cqe_pkg::ST_DRAINED;
                        end
                        else
                        begin
                            head_next   = wrap_next(head_reg);
                            status_next = cqe_pkg::ST_OK;
                        end
                    end
                end
                cqe_pkg::CMD_TRAV:
                begin
                    if (empty)
                    begin
                        status_next = cqe_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        rd_en        = 1'b1;
                        sel_ram_next = 1'b1;
                        trav_next    = wrap_next(head_reg);
                        left_next    = occ_reg - 1'b1;
                        status_next  = cqe_pkg::ST_OK;
                    end
                end
                default:
                begin
                    status_next = cqe_pkg::ST_EMPTY;
                end
            endcase
        end
        else if (ctl.step)
        begin
            rd_en     = 1'b1;
            rd_addr   = trav_reg;
            trav_next = wrap_next(trav_reg);
            left_next = left_reg - 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            tail_reg    <= '0;
            occ_reg     <= '0;
            trav_reg    <= '0;
            left_reg    <= '0;
            status_reg  <= cqe_pkg::ST_OK;
            sel_ram_reg <= 1'b0;
        end
        else
        begin
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            occ_reg     <= occ_next;
            trav_reg    <= trav_next;
            left_reg    <= left_next;
            status_reg  <= status_next;
            sel_ram_reg <= sel_ram_next;
        end
    end

    // Ring storage.
    cqe_ram #(
        .WIDTH (cqe_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (tail_reg),
        .wr_data (data_in),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Result fields.
    assign status    = status_reg;
    assign data_out  = sel_ram_reg ? $signed(rd_data) : '0;
    assign last      = (left_reg == '0);
    assign stat.last = last;

    `CQE_ASSERT(a_occ_bounded, occ_reg <= CNT_W'(DEPTH))
    `CQE_ASSERT_IMPLIES(a_ring_ends_meet, (occ_reg == '0) || (occ_reg == CNT_W'(DEPTH)),
        head_reg == tail_reg)
    `CQE_ASSERT_IMPLIES(a_step_has_work, ctl.step, left_reg != '0)

endmodule

/* sv/cqe_ctrl.sv */
// Controller of the circular queue engine: request intake and result emission.
// Depends on cqe_pkg.
module cqe_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  cqe_pkg::dp_stat_t stat,
    output cqe_pkg::ctl_t     ctl
);

    cqe_pkg::fsm_state_t state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cqe_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            cqe_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = cqe_pkg::S_EMIT;
                end
            end
            cqe_pkg::S_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (stat.last)
                    begin
                        state_next = cqe_pkg::S_IDLE;
                    end
                    else
                    begin
                        ctl.step = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = cqe_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* sv/circular_queue_engine.sv */
// Circular queue engine: a ring-buffer queue of DEPTH signed 32-bit words.
// Latency: a result is shown the cycle after its request is taken.
// Throughput: a request is taken only once every result of the one before it is
// taken; traverse values flow one per cycle while res_ch.ready holds.
// Reset clears head, tail and occupancy at once; storage is not cleared and
// needs no clearing pass, so a request is taken in the first cycle after reset.
module circular_queue_engine #(
    parameter int DEPTH = 8
) (
    input logic       clk,
    input logic       rst_n,
    cqe_cmd_if.sink   cmd_ch,
    cqe_res_if.source res_ch
);

    cqe_pkg::ctl_t     ctl;
    cqe_pkg::dp_stat_t stat;

    // Sequencing of requests and results.
    cqe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd_ch.valid),
        .in_ready  (cmd_ch.ready),
        .out_valid (res_ch.valid),
        .out_ready (res_ch.ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    // Queue state and storage.
    cqe_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .command  (cmd_ch.command),
        .data_in  (cmd_ch.data_in),
        .stat     (stat),
        .status   (res_ch.status),
        .data_out (res_ch.data_out),
        .last     (res_ch.last)
    );

endmodule
